// ----- rtl/bdre_pkg.sv -----
// Shared types and constants for the byte difference run encoder.
// No dependencies; all other files of the block import this package.
`timescale 1ns / 1ps

package bdre_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_CNT_W  = 24;
  localparam int INDEX_BITS_DEF = 24;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CONT  = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // one queue entry: everything one item contributes to the result stream
  typedef struct packed {
    logic                  has_byte;
    logic                  run_first;
    logic [OUT_CNT_W-1:0]  run_offset;
    logic [BYTE_W-1:0]     data_byte;
    logic [OUT_CNT_W-1:0]  run_length;
    logic [OUT_CNT_W-1:0]  correction_count;
    logic                  has_sum;
    logic [BYTE_W-1:0]     new_checksum;
    logic [BYTE_W-1:0]     old_checksum;
  } bdre_entry_t;

endpackage

// ----- rtl/bdre_in_if.sv -----
// Input channel of the byte difference run encoder: valid/ready plus one position.
// Depends on bdre_pkg.
`timescale 1ns / 1ps

interface bdre_in_if;
  import bdre_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] new_byte;
  logic [BYTE_W-1:0] old_byte;
  logic              new_present;
  logic              old_present;
  logic              final_position;

  modport source (
    output valid, new_byte, old_byte, new_present, old_present, final_position,
    input  ready
  );
  modport sink (
    input  valid, new_byte, old_byte, new_present, old_present, final_position,
    output ready
  );
endinterface

// ----- rtl/bdre_out_if.sv -----
// Result channel of the byte difference run encoder: valid/ready plus one result.
// Depends on bdre_pkg.
`timescale 1ns / 1ps

interface bdre_out_if;
  import bdre_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [OUT_CNT_W-1:0] run_offset;
  logic [BYTE_W-1:0]    data_byte;
  logic [OUT_CNT_W-1:0] run_length;
  logic [BYTE_W-1:0]    new_checksum;
  logic [BYTE_W-1:0]    old_checksum;
  logic [OUT_CNT_W-1:0] correction_count;
  logic                 last_result;

  modport source (
    output valid, kind, run_offset, data_byte, run_length, new_checksum,
           old_checksum, correction_count, last_result,
    input  ready
  );
  modport sink (
    input  valid, kind, run_offset, data_byte, run_length, new_checksum,
           old_checksum, correction_count, last_result,
    output ready
  );
endinterface

// ----- rtl/bdre_front.sv -----
// Front end: accepts positions, keeps run and checksum state, and queues the
// results each position causes. Depends on bdre_pkg and bdre_in_if.
`timescale 1ns / 1ps

module bdre_front #(
  parameter int INDEX_BITS = bdre_pkg::INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bdre_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output bdre_pkg::bdre_entry_t q_entry
);
  import bdre_pkg::*;

  logic [INDEX_BITS-1:0] pos_r, pos_nxt;
  logic                  run_open_r, run_open_nxt;
  logic [INDEX_BITS-1:0] run_start_r, run_start_nxt;
  logic [INDEX_BITS-1:0] run_count_r, run_count_nxt;
  logic [BYTE_W-1:0]     new_xor_r, new_xor_nxt;
  logic [BYTE_W-1:0]     old_xor_r, old_xor_nxt;
  logic [INDEX_BITS-1:0] runs_total_r, runs_total_nxt;

  logic accept;
  logic differs;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    pos_nxt        = pos_r;
    run_open_nxt   = run_open_r;
    run_start_nxt  = run_start_r;
    run_count_nxt  = run_count_r;
    new_xor_nxt    = new_xor_r;
    old_xor_nxt    = old_xor_r;
    runs_total_nxt = runs_total_r;
    differs        = 1'b0;
    q_push         = 1'b0;
    q_entry        = '0;

    if (accept) begin
      if (in_ch.old_present) begin
        old_xor_nxt = old_xor_r ^ in_ch.old_byte;
      end
      // a new byte past the end of the old file always counts as different
      differs = in_ch.new_present &&
                (!in_ch.old_present || (in_ch.new_byte != in_ch.old_byte));
      if (in_ch.new_present) begin
        new_xor_nxt = new_xor_r ^ in_ch.new_byte;
      end
      if (differs) begin
        if (!run_open_r) begin
          run_open_nxt   = 1'b1;
          run_start_nxt  = pos_r;
          run_count_nxt  = INDEX_BITS'(1);
          runs_total_nxt = (&runs_total_r) ? runs_total_r
                                           : runs_total_r + INDEX_BITS'(1);
        end else begin
          run_count_nxt  = (&run_count_r) ? run_count_r
                                          : run_count_r + INDEX_BITS'(1);
        end
      end else begin
        run_open_nxt = 1'b0;
      end
      pos_nxt = (&pos_r) ? pos_r : pos_r + INDEX_BITS'(1);

      q_entry.has_byte         = differs;
      q_entry.run_first        = !run_open_r;
      q_entry.run_offset       = OUT_CNT_W'(run_start_nxt);
      q_entry.data_byte        = in_ch.new_byte;
      q_entry.run_length       = OUT_CNT_W'(run_count_nxt);
      q_entry.correction_count = OUT_CNT_W'(runs_total_nxt);
      q_entry.has_sum          = in_ch.final_position;
      q_entry.new_checksum     = new_xor_nxt;
      q_entry.old_checksum     = old_xor_nxt;
      q_push                   = differs || in_ch.final_position;

      // end of stream: back to the reset state for the next stream
      if (in_ch.final_position) begin
        pos_nxt        = '0;
        run_open_nxt   = 1'b0;
        run_start_nxt  = '0;
        run_count_nxt  = '0;
        new_xor_nxt    = '0;
        old_xor_nxt    = '0;
        runs_total_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      run_open_r   <= 1'b0;
      run_start_r  <= '0;
      run_count_r  <= '0;
      new_xor_r    <= '0;
      old_xor_r    <= '0;
      runs_total_r <= '0;
    end else begin
      pos_r        <= pos_nxt;
      run_open_r   <= run_open_nxt;
      run_start_r  <= run_start_nxt;
      run_count_r  <= run_count_nxt;
      new_xor_r    <= new_xor_nxt;
      old_xor_r    <= old_xor_nxt;
      runs_total_r <= runs_total_nxt;
    end
  end

endmodule

// ----- rtl/bdre_fifo.sv -----
// Short queue of result entries between the front and back ends.
// Depends on bdre_pkg.
`timescale 1ns / 1ps

module bdre_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bdre_pkg::bdre_entry_t din,
  input  logic                  pop,
  output bdre_pkg::bdre_entry_t dout,
  output logic                  full,
  output logic                  empty
);
  import bdre_pkg::*;

  bdre_entry_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/bdre_back.sv -----
// Back end: drains queue entries into the registered result channel, byte
// result first, then the summary. Depends on bdre_pkg and bdre_out_if.
`timescale 1ns / 1ps

module bdre_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdre_pkg::bdre_entry_t q_entry,
  input  logic                  q_empty,
  output logic                  q_pop,
  bdre_out_if.source            out_ch
);
  import bdre_pkg::*;

  logic                 out_valid_r, out_valid_nxt;
  logic                 sum_phase_r, sum_phase_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [OUT_CNT_W-1:0] offset_r, offset_nxt;
  logic [BYTE_W-1:0]    data_r, data_nxt;
  logic [OUT_CNT_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0]    nsum_r, nsum_nxt;
  logic [BYTE_W-1:0]    osum_r, osum_nxt;
  logic [OUT_CNT_W-1:0] count_r, count_nxt;
  logic                 last_r, last_nxt;
  logic                 load;

  // output register can take a new beat when empty or being drained
  assign load = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sum_phase_nxt = sum_phase_r;
    kind_nxt      = kind_r;
    offset_nxt    = offset_r;
    data_nxt      = data_r;
    length_nxt    = length_r;
    nsum_nxt      = nsum_r;
    osum_nxt      = osum_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        count_nxt = q_entry.correction_count;
        if (q_entry.has_byte && !sum_phase_r) begin
          kind_nxt   = q_entry.run_first ? KIND_START : KIND_CONT;
          offset_nxt = q_entry.run_offset;
          data_nxt   = q_entry.data_byte;
          length_nxt = q_entry.run_length;
          nsum_nxt   = '0;
          osum_nxt   = '0;
          last_nxt   = 1'b0;
          if (q_entry.has_sum) begin
            sum_phase_nxt = 1'b1;
          end else begin
            q_pop = 1'b1;
          end
        end else begin
          kind_nxt      = KIND_SUM;
          offset_nxt    = '0;
          data_nxt      = '0;
          length_nxt    = '0;
          nsum_nxt      = q_entry.new_checksum;
          osum_nxt      = q_entry.old_checksum;
          last_nxt      = 1'b1;
          sum_phase_nxt = 1'b0;
          q_pop         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_phase_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sum_phase_r <= sum_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    offset_r <= offset_nxt;
    data_r   <= data_nxt;
    length_r <= length_nxt;
    nsum_r   <= nsum_nxt;
    osum_r   <= osum_nxt;
    count_r  <= count_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = kind_r;
  assign out_ch.run_offset       = offset_r;
  assign out_ch.data_byte        = data_r;
  assign out_ch.run_length       = length_r;
  assign out_ch.new_checksum     = nsum_r;
  assign out_ch.old_checksum     = osum_r;
  assign out_ch.correction_count = count_r;
  assign out_ch.last_result      = last_r;

endmodule

// ----- rtl/byte_diff_run_encoder_core.sv -----
// Byte difference run encoder, top level.
// Input channel in_ch: one byte position of the old and new file per beat.
// Result channel out_ch: run start bytes (with the run offset), continuing run
// bytes (with the updated run length) and, after the final position, one
// summary beat with both XOR checksums, the correction count and last_result.
// A position causes zero, one or two result beats; nothing else is reported.
// The first result of a position passes through the result queue and then the
// output register before it is on out_ch.
// Throughput: one position per cycle while the result queue is not full; the output
// side moves one result per cycle while out_ch.ready is high, so the second result
// of a final position with a byte is absorbed by the 4-entry result queue.
// The front end stalls in_ch only when that queue is full; out_ch has its own
// output register, so input beats keep flowing while a result waits.
// Reset (synchronous, rst_n low) clears the position, run and checksum state
// and empties the queue; the same state is cleared after every final position.
// Counters are INDEX_BITS wide, saturate at their limit, and are reported in
// their low 24 bits.
// Depends on bdre_pkg, bdre_in_if, bdre_out_if, bdre_front, bdre_fifo, bdre_back.
`timescale 1ns / 1ps

module byte_diff_run_encoder_core #(
  parameter int INDEX_BITS = bdre_pkg::INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bdre_in_if.sink    in_ch,
  bdre_out_if.source out_ch
);
  import bdre_pkg::*;

  bdre_entry_t q_in_entry;
  bdre_entry_t q_head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  bdre_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in_entry)
  );

  bdre_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in_entry),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  bdre_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
